// ===== sv/tcc_pkg.sv =====
// Shared types, widths and constants for the thermocouple temperature converter.
// Used by tcc_ctrl, tcc_dp, the top level and the checker; depends on nothing.

package tcc_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int OUT_W       = 24;
  localparam int COEF_W      = 40;
  localparam int GAIN_W      = 16;
  localparam int NUM_COEF    = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;

  // Datapath widths: one signed 25 x 30 multiplier, 48-bit Horner accumulator
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 30;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 48;
  localparam int ACC_SPLIT = 24;
  localparam int EMF_W     = 30;
  localparam int SUM_W     = 56;

  // Scale factors and offsets
  localparam logic signed [MUL_B_W-1:0] CJ_SCALE  = 30'sd232731;
  localparam logic signed [MUL_B_W-1:0] EMF_SCALE = 30'sd2457638;
  localparam logic signed [SUM_W-1:0]   CJ_OFFSET = 56'sd69120;
  localparam logic signed [SUM_W-1:0]   TC_OFFSET = 56'sd512;
  localparam logic [GAIN_W-1:0]         GAIN_RESET = 16'd4424;

  // Rounding halves and limits
  localparam logic signed [SUM_W-1:0] RND8    = 56'sd128;
  localparam logic signed [SUM_W-1:0] RND12   = 56'sd2048;
  localparam logic signed [SUM_W-1:0] RND16   = 56'sd32768;
  localparam logic signed [SUM_W-1:0] RND24   = 56'sd8388608;
  localparam logic signed [SUM_W-1:0] ACC_LIM = 56'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] OUT_MAX = 56'sd8388607;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -56'sd8388608;

  // Register indexes on the configuration port
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_COEFF_FIRST   = 3'd0;
  localparam cfg_idx_t CFG_COEFF_SECOND  = 3'd1;
  localparam cfg_idx_t CFG_COEFF_THIRD   = 3'd2;
  localparam cfg_idx_t CFG_COEFF_FOURTH  = 3'd3;
  localparam cfg_idx_t CFG_COEFF_FIFTH   = 3'd4;
  localparam cfg_idx_t CFG_COEFF_SIXTH   = 3'd5;
  localparam cfg_idx_t CFG_COEFF_SEVENTH = 3'd6;
  localparam cfg_idx_t CFG_GAIN          = 3'd7;

  // Coefficient select for a Horner step; COEF_NONE marks the final multiply
  typedef logic [CFG_IDX_W-1:0] coef_idx_t;
  localparam coef_idx_t COEF_LAST_ADD = CFG_COEFF_SIXTH;
  localparam coef_idx_t COEF_NONE     = 3'd7;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_CJ   = 3'd0,
    MUL_EMF  = 3'd1,
    MUL_LO   = 3'd2,
    MUL_HI   = 3'd3,
    MUL_GAIN = 3'd4
  } mul_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load_sample;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      save_lo;
    logic      load_cold;
    logic      load_emf;
    logic      acc_step;
    coef_idx_t coef_sel;
    logic      load_junc;
    logic      load_out;
  } tcc_cmd_t;

  // Reset value of each polynomial coefficient (K-type inverse set, Q8.32)
  function automatic logic signed [COEF_W-1:0] coef_reset(input coef_idx_t idx);
    logic signed [COEF_W-1:0] val;
    case (idx)
      CFG_COEFF_FIRST:   val = 40'sd107733026918;
      CFG_COEFF_SECOND:  val = 40'sd337588982;
      CFG_COEFF_THIRD:   val = -40'sd1075086578;
      CFG_COEFF_FOURTH:  val = 40'sd357138117;
      CFG_COEFF_FIFTH:   val = -40'sd52743658;
      CFG_COEFF_SIXTH:   val = 40'sd4210801;
      CFG_COEFF_SEVENTH: val = -40'sd189538;
      default:           val = '0;
    endcase
    return val;
  endfunction

  // Clamp a wide signed value to the 24-bit output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > OUT_MAX) begin
      c = OUT_MAX;
    end else if (v < OUT_MIN) begin
      c = OUT_MIN;
    end else begin
      c = v;
    end
    return c[OUT_W-1:0];
  endfunction

endpackage

// ===== sv/tcc_ctrl.sv =====
// Sequencing state machine of the thermocouple converter: handshakes, phase,
// Horner step counter and datapath commands. Depends on tcc_pkg.

module tcc_ctrl import tcc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output tcc_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CJ_MUL = 11'b000_0000_0010,
    S_CJ_WR  = 11'b000_0000_0100,
    S_E_MUL  = 11'b000_0000_1000,
    S_E_WR   = 11'b000_0001_0000,
    S_H_LO   = 11'b000_0010_0000,
    S_H_HI   = 11'b000_0100_0000,
    S_H_ADD  = 11'b000_1000_0000,
    S_JUNC   = 11'b001_0000_0000,
    S_T_MUL  = 11'b010_0000_0000,
    S_T_WR   = 11'b100_0000_0000
  } state_t;

  state_t    state, state_next;
  logic      phase, phase_next;
  coef_idx_t cnt, cnt_next;
  logic      out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel  = MUL_CJ;
    cmd.coef_sel = cnt;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_sample = 1'b1;
          phase_next      = !phase;
          state_next      = phase ? S_E_MUL : S_CJ_MUL;
        end
      end
      S_CJ_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CJ;
        state_next  = S_CJ_WR;
      end
      S_CJ_WR: begin
        cmd.load_cold = 1'b1;
        state_next    = S_IDLE;
      end
      S_E_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EMF;
        state_next  = S_E_WR;
      end
      S_E_WR: begin
        cmd.load_emf = 1'b1;
        cnt_next     = COEF_LAST_ADD;
        state_next   = S_H_LO;
      end
      S_H_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        state_next  = S_H_HI;
      end
      S_H_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        cmd.save_lo = 1'b1;
        state_next  = S_H_ADD;
      end
      S_H_ADD: begin
        cmd.acc_step = 1'b1;
        if (cnt == COEF_NONE) begin
          state_next = S_JUNC;
        end else begin
          // wraps from the first coefficient to COEF_NONE for the final multiply
          cnt_next   = cnt - 1'b1;
          state_next = S_H_LO;
        end
      end
      S_JUNC: begin
        cmd.load_junc = 1'b1;
        state_next    = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_next  = S_T_WR;
      end
      S_T_WR: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= 1'b0;
      cnt      <= COEF_NONE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/tcc_dp.sv =====
// Datapath of the thermocouple converter: configuration registers, shared
// multiplier, Horner accumulator and output registers. Depends on tcc_pkg.

module tcc_dp import tcc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  tcc_cmd_t                     cmd,
  input  logic signed [SAMPLE_W-1:0]   sample_in,
  input  logic                         cfg_we,
  input  cfg_idx_t                     cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic signed [OUT_W-1:0]      temperature,
  output logic signed [OUT_W-1:0]      junction_temperature,
  output logic signed [OUT_W-1:0]      reference_temperature
);

  logic signed [SAMPLE_W-1:0] sample;
  logic signed [COEF_W-1:0]   coef [NUM_COEF];
  logic [GAIN_W-1:0]          gain;
  logic signed [EMF_W-1:0]    emf;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod, lo_prod;
  logic signed [OUT_W-1:0]    cold, junc;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [COEF_W-1:0]   coef_add;
  logic signed [SUM_W-1:0]    prod_w, lo_w, acc_w;
  logic signed [SUM_W-1:0]    emf_full, cold_full, horner, junc_full, temp_full;
  logic signed [SUM_W-1:0]    acc_next;

  // Select multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_CJ: begin
        mul_a = MUL_A_W'(sample);
        mul_b = CJ_SCALE;
      end
      MUL_EMF: begin
        mul_a = MUL_A_W'(sample);
        mul_b = EMF_SCALE;
      end
      MUL_LO: begin
        mul_a = $signed({1'b0, acc[ACC_SPLIT-1:0]});
        mul_b = emf;
      end
      MUL_HI: begin
        mul_a = MUL_A_W'($signed(acc[ACC_W-1:ACC_SPLIT]));
        mul_b = emf;
      end
      MUL_GAIN: begin
        mul_a = MUL_A_W'(junc) + MUL_A_W'(cold);
        mul_b = MUL_B_W'($signed({1'b0, gain}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign coef_add = (cmd.coef_sel == COEF_NONE) ? '0 : coef[cmd.coef_sel];

  // Rounding, offsets and the Horner sum
  always_comb begin
    prod_w    = SUM_W'(prod);
    lo_w      = SUM_W'(lo_prod);
    acc_w     = SUM_W'(acc);
    emf_full  = (prod_w + RND8) >>> 8;
    cold_full = ((prod_w + RND16) >>> 16) - CJ_OFFSET;
    horner    = prod_w + ((lo_w + RND24) >>> 24) + SUM_W'(coef_add);
    junc_full = ((acc_w + RND24) >>> 24) - TC_OFFSET;
    temp_full = (prod_w + RND12) >>> 12;
    if (horner > ACC_LIM) begin
      acc_next = ACC_LIM;
    end else if (horner < -ACC_LIM) begin
      acc_next = -ACC_LIM;
    end else begin
      acc_next = horner;
    end
  end

  // Configuration registers and stored cold-junction temperature
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= coef_reset(CFG_IDX_W'(i));
      end
      gain <= GAIN_RESET;
      cold <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAIN) begin
          gain <= cfg_data[GAIN_W-1:0];
        end else begin
          coef[cfg_index] <= cfg_data[COEF_W-1:0];
        end
      end
      if (cmd.load_cold) begin
        cold <= sat_out(cold_full);
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample <= sample_in;
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.save_lo) begin
      lo_prod <= prod;
    end
    if (cmd.load_emf) begin
      emf <= emf_full[EMF_W-1:0];
      acc <= ACC_W'(coef[CFG_COEFF_SEVENTH]);
    end else if (cmd.acc_step) begin
      acc <= acc_next[ACC_W-1:0];
    end
    if (cmd.load_junc) begin
      junc <= sat_out(junc_full);
    end
    if (cmd.load_out) begin
      temperature           <= sat_out(temp_full);
      junction_temperature  <= junc;
      reference_temperature <= cold;
    end
  end

endmodule

// ===== sv/thermocouple_temperature_converter_top.sv =====
// Top level of the thermocouple temperature converter with cold-junction
// compensation. Joins tcc_ctrl and tcc_dp; depends on tcc_pkg.
//
//   channel | direction | handshake          | payload
//   s       | in        | s_tvalid/s_tready  | s_tdata[15:0] sample
//   m       | out       | m_tvalid/m_tready  | m_tdata[71:0] temperature, junction, reference
//   cfg     | in        | cfg_we             | cfg_index[2:0], cfg_data[39:0]
//
// A cold-junction sample passes a multiply state and a write state before ready returns.
// A thermocouple sample runs seven Horner steps, each a low half, high half and add
// on the single 25 x 30 multiplier.
// Reset is synchronous; it restores the coefficients, the gain, the phase and
// the stored cold-junction temperature. The output register lets a new sample
// be taken while a result waits; a thermocouple result stalls only at its
// final write while the previous result is still untaken.

module thermocouple_temperature_converter_top import tcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [23:0] temperature, [47:24] junction_temperature,
                                            // [71:48] reference_temperature
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  tcc_cmd_t                cmd;
  logic signed [OUT_W-1:0] temperature;
  logic signed [OUT_W-1:0] junction_temperature;
  logic signed [OUT_W-1:0] reference_temperature;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tcc_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .sample_in             ($signed(s_tdata[SAMPLE_W-1:0])),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .temperature           (temperature),
    .junction_temperature  (junction_temperature),
    .reference_temperature (reference_temperature)
  );

  // Pack result fields, first field lowest
  assign m_tdata = {reference_temperature, junction_temperature, temperature};

endmodule

// ===== sv/tcc_checker.sv =====
// Port-level checks for the thermocouple temperature converter, bound to the
// top level. Depends on tcc_pkg.

module tcc_checker import tcc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Each sample transfer makes the block busy, so ready drops after it
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after a sample transfer");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready) && !$past(s_tvalid && s_tready, 2))
    else $error("result too soon after a sample transfer");

endmodule

bind thermocouple_temperature_converter_top tcc_checker u_tcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
